[sv/gbps_pkg.sv]
package gbps_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;
  localparam int NUM_AXES  = 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF_X = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF_Y = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF_Z = 4'd3;

  // Reset values
  localparam logic [15:0] STEP_DT_RESET  = 16'd655;
  localparam logic [30:0] BOX_HALF_RESET = 31'(64'd1 << FRAC_BITS);

  // Queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] mass;
    logic               last_particle;
  } gbps_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic        [63:0] impulse_x;
    logic        [63:0] impulse_y;
    logic        [63:0] impulse_z;
    logic               end_of_pass;
    logic        [31:0] step_count;
  } gbps_out_t;

  typedef struct packed {
    logic [15:0] step_dt;
    logic [30:0] box_half_x;
    logic [30:0] box_half_y;
    logic [30:0] box_half_z;
  } gbps_cfg_t;

  // Classified particle handed from the front to the back
  typedef struct packed {
    logic [NUM_AXES-1:0][31:0] pos;
    logic [NUM_AXES-1:0][31:0] vel;
    logic [NUM_AXES-1:0][31:0] mag;
    logic [NUM_AXES-1:0]       hit;
    logic [31:0]               mass;
    logic                      last;
  } gbps_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } gbps_q_status_t;

endpackage

[sv/gbps_front.sv]
module gbps_front (
  input  logic                 clk,
  input  logic                 rst,
  input  gbps_pkg::gbps_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbps_pkg::gbps_in_t   in_data,
  input  logic                 q_full,
  output logic                 push,
  output gbps_pkg::gbps_entry_t push_data
);

  localparam int NA = gbps_pkg::NUM_AXES;

  typedef struct packed {
    logic [NA-1:0][31:0] pos;
    logic [NA-1:0][47:0] prod;
    logic [NA-1:0][31:0] vel;
    logic [31:0]         mass;
    logic                last;
  } s1_t;

  typedef struct packed {
    logic [NA-1:0][31:0] pos;
    logic [NA-1:0][31:0] vel;
    logic [31:0]         mass;
    logic                last;
  } s2_t;

  logic v1, v2, v3;
  logic en1, en2, en3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  gbps_pkg::gbps_entry_t s3, s3_next;

  logic [NA-1:0][31:0]  vin;
  logic [NA-1:0][31:0]  pin;
  logic [NA-1:0][48:0]  prod_full;
  logic [NA-1:0][32:0]  moved;
  logic [NA-1:0][30:0]  half;
  logic [NA-1:0][32:0]  p33;
  logic [NA-1:0][32:0]  neg_h33;
  logic [NA-1:0][33:0]  mirror;
  logic [NA-1:0]        hit_hi;
  logic [NA-1:0]        hit_lo;

  // Stage enables: each stage moves when it is empty or its successor moves
  assign en3      = !v3 || !q_full;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign push     = v3 && !q_full;
  assign push_data = s3;

  assign pin  = {in_data.pos_x, in_data.pos_y, in_data.pos_z};
  assign vin  = {in_data.vel_x, in_data.vel_y, in_data.vel_z};
  assign half = {cfg.box_half_x, cfg.box_half_y, cfg.box_half_z};

  // Stage 1: velocity times time step
  always_comb begin
    s1_next.pos  = pin;
    s1_next.vel  = vin;
    s1_next.mass = in_data.mass;
    s1_next.last = in_data.last_particle;
    for (int a = 0; a < NA; a++) begin
      prod_full[a] = 49'($signed(vin[a])) * 49'($signed({1'b0, cfg.step_dt}));
      s1_next.prod[a] = prod_full[a][47:0];
    end
  end

  // Stage 2: floor shift and saturating move
  always_comb begin
    s2_next.vel  = s1.vel;
    s2_next.mass = s1.mass;
    s2_next.last = s1.last;
    for (int a = 0; a < NA; a++) begin
      moved[a] = $signed({s1.pos[a][31], s1.pos[a]})
               + $signed({s1.prod[a][47], s1.prod[a][47:gbps_pkg::DT_BITS]});
      if (moved[a][32] != moved[a][31]) begin
        s2_next.pos[a] = moved[a][32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        s2_next.pos[a] = moved[a][31:0];
      end
    end
  end

  // Stage 3: wall test, mirror and velocity flip
  always_comb begin
    s3_next.mass = s2.mass;
    s3_next.last = s2.last;
    for (int a = 0; a < NA; a++) begin
      p33[a]     = {s2.pos[a][31], s2.pos[a]};
      neg_h33[a] = 33'(-$signed({2'b00, half[a]}));
      hit_hi[a]  = $signed(p33[a]) > $signed({2'b00, half[a]});
      hit_lo[a]  = $signed(p33[a]) < $signed(neg_h33[a]);
      if (hit_hi[a]) begin
        mirror[a] = $signed({2'b00, half[a], 1'b0}) - $signed({p33[a][32], p33[a]});
      end else begin
        mirror[a] = -$signed({2'b00, half[a], 1'b0}) - $signed({p33[a][32], p33[a]});
      end
      s3_next.hit[a] = hit_hi[a] || hit_lo[a];
      s3_next.mag[a] = s2.vel[a][31] ? 32'(-s2.vel[a]) : s2.vel[a];
      // Only the low wall at zero half-size can push the mirror out of range
      if (!s3_next.hit[a]) begin
        s3_next.pos[a] = s2.pos[a];
      end else if (!mirror[a][33] && (mirror[a][32:31] != 2'b00)) begin
        s3_next.pos[a] = 32'h7fff_ffff;
      end else begin
        s3_next.pos[a] = mirror[a][31:0];
      end
      if (!s3_next.hit[a]) begin
        s3_next.vel[a] = s2.vel[a];
      end else if (s2.vel[a] == 32'h8000_0000) begin
        s3_next.vel[a] = 32'h7fff_ffff;
      end else begin
        s3_next.vel[a] = 32'(-s2.vel[a]);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
  end

endmodule

[sv/gbps_queue.sv]
module gbps_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  gbps_pkg::gbps_entry_t   push_data,
  input  logic                    pop,
  output gbps_pkg::gbps_entry_t   pop_data,
  output gbps_pkg::gbps_q_status_t status
);

  localparam int DEPTH = gbps_pkg::QDEPTH;
  localparam int PW    = gbps_pkg::QPTR_W;
  localparam int CW    = gbps_pkg::QCNT_W;

  gbps_pkg::gbps_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign pop_data     = mem[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PW'((32'(wr_ptr) + 1) % DEPTH);
      if (pop)  rd_ptr <= PW'((32'(rd_ptr) + 1) % DEPTH);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[sv/gbps_back.sv]
module gbps_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  pop,
  input  gbps_pkg::gbps_entry_t pop_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gbps_pkg::gbps_out_t   out_data
);

  localparam int NA = gbps_pkg::NUM_AXES;

  typedef struct packed {
    logic [NA-1:0][31:0] pos;
    logic [NA-1:0][31:0] vel;
    logic [NA-1:0][63:0] imp;
    logic                last;
  } b1_t;

  logic vb1;
  logic en_b1, en_out;
  b1_t  b1, b1_next;

  logic [NA-1:0][63:0] acc, acc_next;
  logic [NA-1:0][64:0] acc_sum;
  logic [31:0]         pass_count, pass_count_next;
  gbps_pkg::gbps_out_t out_next;

  assign en_out = !out_valid || out_ready;
  assign en_b1  = !vb1 || en_out;
  assign pop    = !q_empty && en_b1;

  // Impulse product per axis, zero where no wall was hit
  always_comb begin
    b1_next.pos  = pop_data.pos;
    b1_next.vel  = pop_data.vel;
    b1_next.last = pop_data.last;
    for (int a = 0; a < NA; a++) begin
      b1_next.imp[a] = pop_data.hit[a] ? (64'(pop_data.mag[a]) * 64'(pop_data.mass)) : 64'd0;
    end
  end

  // Saturating accumulate, close the pass on the last item
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      acc_sum[a] = {1'b0, acc[a]} + {1'b0, b1.imp[a][62:0], 1'b0};
      acc_next[a] = acc_sum[a][64] ? {64{1'b1}} : acc_sum[a][63:0];
    end
    pass_count_next      = pass_count + 32'd1;
    out_next.new_pos_x   = b1.pos[2];
    out_next.new_pos_y   = b1.pos[1];
    out_next.new_pos_z   = b1.pos[0];
    out_next.new_vel_x   = b1.vel[2];
    out_next.new_vel_y   = b1.vel[1];
    out_next.new_vel_z   = b1.vel[0];
    out_next.end_of_pass = b1.last;
    out_next.impulse_x   = b1.last ? acc_next[2] : 64'd0;
    out_next.impulse_y   = b1.last ? acc_next[1] : 64'd0;
    out_next.impulse_z   = b1.last ? acc_next[0] : 64'd0;
    out_next.step_count  = b1.last ? pass_count_next : 32'd0;
  end

  // Control and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      vb1        <= 1'b0;
      out_valid  <= 1'b0;
      acc        <= '0;
      pass_count <= '0;
    end else begin
      if (en_b1) vb1 <= pop;
      if (en_out) out_valid <= vb1;
      if (en_out && vb1) begin
        if (b1.last) begin
          acc        <= '0;
          pass_count <= pass_count_next;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en_b1) b1 <= b1_next;
    if (en_out && vb1) out_data <= out_next;
  end

endmodule

[sv/gas_box_particle_step.sv]
// Particle step in a reflecting box. One particle is taken per clock and
// one updated particle comes out per clock while out_ready is high; the
// front (move, wall test) and the back (impulse multiply, running totals,
// output register) are joined by a four-item queue, so a stall on the
// output fills that queue before the input stops. An item passes through
// three front stages (the first loads at the accepting edge), the queue,
// the impulse multiplier stage and the output register. The only links
// between items are the saturating impulse add and the pass count in the
// back, which set nothing slower than one item per clock. An item with
// last_particle set also carries the three pass impulse totals and the new
// pass count, and clears the totals. Configuration writes are always taken
// and should only be made while no item is in flight.
module gas_box_particle_step (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  gbps_pkg::gbps_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output gbps_pkg::gbps_out_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gbps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                           cfg_data
);

  gbps_pkg::gbps_cfg_t      cfg;
  gbps_pkg::gbps_entry_t    push_data, pop_data;
  gbps_pkg::gbps_q_status_t q_status;
  logic                     push, pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_dt    <= gbps_pkg::STEP_DT_RESET;
      cfg.box_half_x <= gbps_pkg::BOX_HALF_RESET;
      cfg.box_half_y <= gbps_pkg::BOX_HALF_RESET;
      cfg.box_half_z <= gbps_pkg::BOX_HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbps_pkg::CFG_STEP_DT:    cfg.step_dt    <= cfg_data[15:0];
        gbps_pkg::CFG_BOX_HALF_X: cfg.box_half_x <= cfg_data[30:0];
        gbps_pkg::CFG_BOX_HALF_Y: cfg.box_half_y <= cfg_data[30:0];
        gbps_pkg::CFG_BOX_HALF_Z: cfg.box_half_z <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  gbps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_status.full),
    .push      (push),
    .push_data (push_data)
  );

  gbps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  gbps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= gbps_pkg::QCNT_W'(gbps_pkg::QDEPTH))
    else $error("queue overfilled");

  // Never push into a full queue nor pop from an empty one
  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("queue push when full or pop when empty");

  // Results that do not close a pass carry no totals
  a_mid_pass_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.end_of_pass) |->
      (out_data.impulse_x == 64'd0 && out_data.impulse_y == 64'd0 &&
       out_data.impulse_z == 64'd0 && out_data.step_count == 32'd0))
    else $error("totals shown on a mid-pass result");

  // Nothing leaves the block in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule
